>>> design/php_pkg.sv
// Shared types and constants for the packet header parser.
package php_pkg;

  // Byte values that steer header decoding
  localparam logic [7:0] TAG_CLASS_MASK = 8'hC0;
  localparam logic [7:0] TAG_OLD_FORMAT = 8'h80;
  localparam logic [7:0] TAG_NEW_FORMAT = 8'hC0;
  localparam logic [7:0] LEN_TWO_LIMIT  = 8'hC0;
  localparam logic [7:0] LEN_TWO_MASK   = 8'hE0;
  localparam logic [7:0] LEN_HIGH_MASK  = 8'h3F;
  localparam logic [31:0] LEN_TWO_BIAS  = 32'd192;

  // Old-format length-of-length code that is not supported
  localparam logic [1:0] OLD_CODE_BAD = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;
  localparam logic [1:0] ST_END   = 2'd3;

  // One classified input byte, as held in the queue
  typedef struct packed {
    logic       eoi;        // end of stream, no byte carried
    logic [7:0] data;       // raw byte
    logic       old_ok;     // old-format tag with a supported length code
    logic       new_tag;    // new-format tag
    logic [2:0] old_bytes;  // length bytes that follow an old-format tag
    logic       len_one;    // new-format length complete in this byte
    logic       len_two;    // new-format length needs a second byte
  } php_item_t;

endpackage

>>> design/php_front.sv
// Front end: accept input bytes and classify them for the decoder.
module php_front (
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic [0:0]         in_tuser,
  input  logic               q_full,
  output logic               q_push,
  output php_pkg::php_item_t q_item
);
  import php_pkg::*;

  logic [1:0] code;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign code      = in_tdata[1:0];

  always_comb begin
    q_item         = '0;
    q_item.eoi     = in_tuser[0];
    q_item.data    = in_tdata;
    q_item.old_ok  = ((in_tdata & TAG_CLASS_MASK) == TAG_OLD_FORMAT) && (code != OLD_CODE_BAD);
    q_item.new_tag = (in_tdata & TAG_CLASS_MASK) == TAG_NEW_FORMAT;
    case (code)
      2'd0:    q_item.old_bytes = 3'd1;
      2'd1:    q_item.old_bytes = 3'd2;
      2'd2:    q_item.old_bytes = 3'd4;
      default: q_item.old_bytes = 3'd0;
    endcase
    q_item.len_one = in_tdata < LEN_TWO_LIMIT;
    q_item.len_two = (in_tdata & LEN_TWO_MASK) == LEN_TWO_LIMIT;
  end

endmodule

>>> design/php_queue.sv
// Short queue of classified bytes between front end and decoder.
module php_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  php_pkg::php_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               pop_valid,
  output php_pkg::php_item_t pop_item
);
  import php_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  php_item_t         entries_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  assign full      = count_r == CW'(DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_item  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/php_back.sv
// Decoder: run the header state machine and hold the result register.
module php_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  php_pkg::php_item_t q_item,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [39:0]        out_tdata,
  output logic [1:0]         out_tuser
);
  import php_pkg::*;

  typedef enum logic [3:0] {
    PH_TAG        = 4'b0001,
    PH_OLD_LEN    = 4'b0010,
    PH_NEW_FIRST  = 4'b0100,
    PH_NEW_SECOND = 4'b1000
  } php_phase_t;

  php_phase_t  phase_r, phase_nxt;
  logic [7:0]  held_tag_r, held_tag_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  bytes_left_r, bytes_left_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_tag_r;
  logic [31:0] out_len_r;
  logic [1:0]  out_status_r;

  logic        emit;
  logic [7:0]  emit_tag;
  logic [31:0] emit_len;
  logic [1:0]  emit_status;
  logic [31:0] acc_shift;
  logic [2:0]  bytes_dec;

  assign q_pop      = q_valid && (!out_valid_r || out_tready);
  assign acc_shift  = {acc_r[23:0], q_item.data};
  assign bytes_dec  = (bytes_left_r != 3'd0) ? bytes_left_r - 3'd1 : 3'd0;

  always_comb begin
    phase_nxt      = phase_r;
    held_tag_nxt   = held_tag_r;
    acc_nxt        = acc_r;
    bytes_left_nxt = bytes_left_r;
    emit           = 1'b0;
    emit_tag       = '0;
    emit_len       = '0;
    emit_status    = ST_OK;
    if (q_pop) begin
      if (q_item.eoi) begin
        emit        = 1'b1;
        emit_status = (phase_r == PH_TAG) ? ST_END : ST_TRUNC;
      end else begin
        case (phase_r)
          PH_OLD_LEN: begin
            acc_nxt        = acc_shift;
            bytes_left_nxt = bytes_dec;
            if (bytes_dec == 3'd0) begin
              emit     = 1'b1;
              emit_tag = held_tag_r;
              emit_len = acc_shift;
            end
          end
          PH_NEW_FIRST: begin
            if (q_item.len_one) begin
              acc_nxt  = {24'd0, q_item.data};
              emit     = 1'b1;
              emit_tag = held_tag_r;
              emit_len = {24'd0, q_item.data};
            end else if (q_item.len_two) begin
              acc_nxt   = {24'd0, q_item.data & LEN_HIGH_MASK};
              phase_nxt = PH_NEW_SECOND;
            end else begin
              emit        = 1'b1;
              emit_status = ST_BAD;
            end
          end
          PH_NEW_SECOND: begin
            acc_nxt  = acc_shift + LEN_TWO_BIAS;
            emit     = 1'b1;
            emit_tag = held_tag_r;
            emit_len = acc_shift + LEN_TWO_BIAS;
          end
          default: begin
            // waiting for a tag byte
            held_tag_nxt = q_item.data;
            acc_nxt      = '0;
            if (q_item.old_ok) begin
              bytes_left_nxt = q_item.old_bytes;
              phase_nxt      = PH_OLD_LEN;
            end else if (q_item.new_tag) begin
              phase_nxt = PH_NEW_FIRST;
            end else begin
              emit        = 1'b1;
              emit_status = ST_BAD;
            end
          end
        endcase
      end
      if (emit) begin
        phase_nxt      = PH_TAG;
        bytes_left_nxt = 3'd0;
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TAG;
      bytes_left_r <= 3'd0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_tag_r <= held_tag_nxt;
    acc_r      <= acc_nxt;
    if (emit) begin
      out_tag_r    <= emit_tag;
      out_len_r    <= emit_len;
      out_status_r <= emit_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_tag_r};
  assign out_tuser  = out_status_r;

endmodule

>>> design/packet_header_parser.sv
// Top level of the packet header parser: front end, queue and decoder.
//
//  channel | direction | tdata                          | tuser
//  --------+-----------+--------------------------------+-----------------
//  in_     | slave     | [7:0] data_byte                | [0] end_of_input
//  out_    | master    | [7:0] tag_byte, [39:8] length  | [1:0] status
//
// Sustains one byte per cycle while the queue has room. A taken byte is
// written into the queue and popped by the decoder once the result register
// is free or draining; a completed result is shown on out_ from that register.
// Reset is synchronous and active low; it empties the queue, returns the
// decoder to waiting for a tag byte and drops any pending result.
// Back-pressure on out_ stalls only the decoder; the queue of QUEUE_DEPTH
// entries keeps taking bytes until it fills, then in_tready falls.
module packet_header_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions: one stream byte or an end-of-stream mark
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] end_of_input
  // result transactions
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] tag_byte, [39:8] body_length
  output logic [1:0]  out_tuser   // [1:0] status
);
  import php_pkg::*;

  // Front end to queue
  logic      q_push;
  logic      q_full;
  php_item_t q_push_item;

  // Queue to decoder
  logic      q_pop;
  logic      q_valid;
  php_item_t q_pop_item;

  // Classify each accepted byte; hold off input only when the queue is full
  php_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_push_item)
  );

  // Decouple input acceptance from result back-pressure
  php_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_pop_item)
  );

  // Advance the header state machine by one queued byte per cycle whenever
  // the result register is free or being drained
  php_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_pop_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> design/php_checker.sv
// Port-level checks for the packet header parser, bound to the top level.
module php_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import php_pkg::*;

  // No result is pending right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Failed or end results carry no tag and no length
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("non-ok result with payload");

  // A parsed header always carries a tag with its top bit set
  a_ok_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OK |-> out_tdata[7])
    else $error("ok result with invalid tag");

endmodule

bind packet_header_parser php_checker u_php_checker (.*);
